// File: rtl/ppm_pkg.sv
// Shared types and constants for the projective point map pipeline.
// No dependencies; used by the divider stage and the top level.
package ppm_pkg;

	localparam int COEF_W         = 48;
	localparam int DIM_W          = 13;
	localparam int OUT_W          = 16;
	localparam int QUOT_BITS      = 16;
	localparam int Q_W            = QUOT_BITS + 1;
	localparam int FAR_LIMIT_BITS = 40;
	localparam int SCALE_BITS     = 20;
	localparam int FP_W           = FAR_LIMIT_BITS + SCALE_BITS;
	localparam int APB_AW         = 3;
	localparam int APB_DW         = 32;

	localparam logic [SCALE_BITS-1:0] INF_SCALE  = 20'd1000000;
	localparam logic [Q_W-1:0]        SAT_MAG    = 17'h10000;
	localparam logic [DIM_W-1:0]      COLS_RESET = 13'd1280;
	localparam logic [DIM_W-1:0]      ROWS_RESET = 13'd960;

	// register index taken from paddr[2]
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	typedef struct packed {
		logic neg_c;    // column result is negative
		logic neg_r;    // row result is negative
		logic skip_c;   // column magnitude already final
		logic skip_r;   // row magnitude already final
		logic far;      // w was zero
		logic uv_zero;  // u and v both zero
	} ppm_flags_t;

endpackage

// File: rtl/ppm_div_stage.sv
// One restoring-division step for the column and row quotients.
// Depends on ppm_pkg for the flag struct and quotient width.
module ppm_div_stage import ppm_pkg::*; #(
	parameter int MAG_W = 63,
	parameter int SHIFT = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [MAG_W-1:0] in_rem_u,
	input  logic [MAG_W-1:0] in_rem_v,
	input  logic [MAG_W-1:0] in_div,
	input  logic [Q_W-1:0]   in_q_c,
	input  logic [Q_W-1:0]   in_q_r,
	input  ppm_flags_t       in_flags,
	output logic             out_valid,
	output logic [MAG_W-1:0] out_rem_u,
	output logic [MAG_W-1:0] out_rem_v,
	output logic [MAG_W-1:0] out_div,
	output logic [Q_W-1:0]   out_q_c,
	output logic [Q_W-1:0]   out_q_r,
	output ppm_flags_t       out_flags
);

	localparam int EXT_W = MAG_W + SHIFT;

	logic             valid_q;
	logic [MAG_W-1:0] rem_u_q, rem_v_q, div_q;
	logic [Q_W-1:0]   q_c_q, q_r_q;
	ppm_flags_t       flags_q;

	logic [EXT_W-1:0] dsh, ru_ext, rv_ext, du, dv;
	logic             fit_u, fit_v;
	logic [MAG_W-1:0] rem_u_nx, rem_v_nx;
	logic [Q_W-1:0]   q_c_nx, q_r_nx;
	logic [Q_W-1:0]   bit_mask;

	always_comb begin
		dsh      = EXT_W'(in_div) << SHIFT;
		ru_ext   = EXT_W'(in_rem_u);
		rv_ext   = EXT_W'(in_rem_v);
		du       = ru_ext - dsh;
		dv       = rv_ext - dsh;
		fit_u    = !in_flags.skip_c && (ru_ext >= dsh);
		fit_v    = !in_flags.skip_r && (rv_ext >= dsh);
		bit_mask = Q_W'(1) << SHIFT;
		rem_u_nx = fit_u ? du[MAG_W-1:0] : in_rem_u;
		rem_v_nx = fit_v ? dv[MAG_W-1:0] : in_rem_v;
		q_c_nx   = fit_u ? (in_q_c | bit_mask) : in_q_c;
		q_r_nx   = fit_v ? (in_q_r | bit_mask) : in_q_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_u_q <= rem_u_nx;
			rem_v_q <= rem_v_nx;
			div_q   <= in_div;
			q_c_q   <= q_c_nx;
			q_r_q   <= q_r_nx;
			flags_q <= in_flags;
		end
	end

	assign out_valid = valid_q;
	assign out_rem_u = rem_u_q;
	assign out_rem_v = rem_v_q;
	assign out_div   = div_q;
	assign out_q_c   = q_c_q;
	assign out_q_r   = q_r_q;
	assign out_flags = flags_q;

endmodule

// File: rtl/projective_point_map.sv
// An accepted request passes registered stages for products, sums and magnitudes, range
// checks and far-point scaling, and divider seeding, then 16 one-bit division steps and
// 1 output register. Throughput: one request per cycle while the result channel is not stalled.
// A stall advances each stage that has room, so bubbles close up and nothing is lost.
// Reset clears every valid bit and sets image_cols to 1280 and image_rows to 960.
// Depends on ppm_pkg and ppm_div_stage.
module projective_point_map import ppm_pkg::*; #(
	parameter int COEF_FRAC_BITS = 32,
	parameter int COORD_BITS     = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [COEF_W-1:0] coef_00,
	input  logic signed [COEF_W-1:0] coef_01,
	input  logic signed [COEF_W-1:0] coef_02,
	input  logic signed [COEF_W-1:0] coef_10,
	input  logic signed [COEF_W-1:0] coef_11,
	input  logic signed [COEF_W-1:0] coef_12,
	input  logic signed [COEF_W-1:0] coef_20,
	input  logic signed [COEF_W-1:0] coef_21,
	input  logic signed [COEF_W-1:0] coef_22,
	input  logic [COORD_BITS-1:0]    pixel_x,
	input  logic [COORD_BITS-1:0]    pixel_y,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  src_col,
	output logic signed [OUT_W-1:0]  src_row,
	output logic                     inside_res,
	output logic                     at_infinity
);

	localparam int PROD_W = COEF_W + COORD_BITS + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int MAG_W  = SUM_W;
	localparam int SAT_W  = MAG_W + QUOT_BITS;

	// ---------------- configuration registers ----------------
	logic [DIM_W-1:0] cols_q, rows_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_COLS: cols_q <= pwdata[DIM_W-1:0];
				REG_ROWS: rows_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COLS: prdata = APB_DW'(cols_q);
			REG_ROWS: prdata = APB_DW'(rows_q);
			default:  prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_out_q;
	logic adv1, adv2, adv3, adv4, adv5, adv_out;
	logic             d_valid [0:QUOT_BITS];
	logic             d_adv   [0:QUOT_BITS];
	logic [MAG_W-1:0] d_rem_u [0:QUOT_BITS];
	logic [MAG_W-1:0] d_rem_v [0:QUOT_BITS];
	logic [MAG_W-1:0] d_div   [0:QUOT_BITS];
	logic [Q_W-1:0]   d_q_c   [0:QUOT_BITS];
	logic [Q_W-1:0]   d_q_r   [0:QUOT_BITS];
	ppm_flags_t       d_flags [0:QUOT_BITS];

	assign adv_out            = !v_out_q || !out_stall;
	assign d_adv[QUOT_BITS]   = adv_out;
	assign adv5               = !v_s5 || d_adv[0];
	assign adv4               = !v_s4 || adv5;
	assign adv3               = !v_s3 || adv4;
	assign adv2               = !v_s2 || adv3;
	assign adv1               = !v_s1 || adv2;
	assign in_stall           = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (adv1)    v_s1    <= in_valid;
			if (adv2)    v_s2    <= v_s1;
			if (adv3)    v_s3    <= v_s2;
			if (adv4)    v_s4    <= v_s3;
			if (adv5)    v_s5    <= v_s4;
			if (adv_out) v_out_q <= d_valid[QUOT_BITS];
		end
	end

	// ---------------- stage 1: products ----------------
	logic signed [COORD_BITS:0]  xs, ys;
	logic signed [PROD_W-1:0]    p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	logic signed [COEF_W-1:0]    c02_s1, c12_s1, c22_s1;

	assign xs = $signed({1'b0, pixel_x});
	assign ys = $signed({1'b0, pixel_y});

	always_ff @(posedge clk) begin
		if (adv1) begin
			p00_s1 <= PROD_W'(coef_00) * PROD_W'(xs);
			p01_s1 <= PROD_W'(coef_01) * PROD_W'(ys);
			p10_s1 <= PROD_W'(coef_10) * PROD_W'(xs);
			p11_s1 <= PROD_W'(coef_11) * PROD_W'(ys);
			p20_s1 <= PROD_W'(coef_20) * PROD_W'(xs);
			p21_s1 <= PROD_W'(coef_21) * PROD_W'(ys);
			c02_s1 <= coef_02;
			c12_s1 <= coef_12;
			c22_s1 <= coef_22;
		end
	end

	// ---------------- stage 2: homogeneous sums ----------------
	logic signed [SUM_W-1:0] u_s2, v_s2_val, w_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			u_s2     <= SUM_W'(p00_s1) + SUM_W'(p01_s1) + SUM_W'(c02_s1);
			v_s2_val <= SUM_W'(p10_s1) + SUM_W'(p11_s1) + SUM_W'(c12_s1);
			w_s2     <= SUM_W'(p20_s1) + SUM_W'(p21_s1) + SUM_W'(c22_s1);
		end
	end

	// ---------------- stage 3: magnitudes and signs ----------------
	logic [MAG_W-1:0] au_s3, av_s3, aw_s3;
	logic             su_s3, sv_s3, sw_s3, uz_s3, vz_s3, wz_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			su_s3 <= u_s2[SUM_W-1];
			sv_s3 <= v_s2_val[SUM_W-1];
			sw_s3 <= w_s2[SUM_W-1];
			au_s3 <= u_s2[SUM_W-1] ? MAG_W'(-u_s2) : MAG_W'(u_s2);
			av_s3 <= v_s2_val[SUM_W-1] ? MAG_W'(-v_s2_val) : MAG_W'(v_s2_val);
			aw_s3 <= w_s2[SUM_W-1] ? MAG_W'(-w_s2) : MAG_W'(w_s2);
			uz_s3 <= (u_s2 == '0);
			vz_s3 <= (v_s2_val == '0);
			wz_s3 <= (w_s2 == '0);
		end
	end

	// ---------------- stage 4: overflow checks, far-point scaling ----------------
	logic [MAG_W-1:0] au_s4, av_s4, aw_s4;
	logic [FP_W-1:0]  fp_c_s4, fp_r_s4;
	logic             fbig_c_s4, fbig_r_s4, sat_c_s4, sat_r_s4;
	logic             neg_c_s4, neg_r_s4, far_s4, uvz_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			au_s4     <= au_s3;
			av_s4     <= av_s3;
			aw_s4     <= aw_s3;
			fp_c_s4   <= FP_W'(au_s3[FAR_LIMIT_BITS-1:0]) * FP_W'(INF_SCALE);
			fp_r_s4   <= FP_W'(av_s3[FAR_LIMIT_BITS-1:0]) * FP_W'(INF_SCALE);
			fbig_c_s4 <= |au_s3[MAG_W-1:FAR_LIMIT_BITS];
			fbig_r_s4 <= |av_s3[MAG_W-1:FAR_LIMIT_BITS];
			// quotient would reach 2^16: saturate without dividing
			sat_c_s4  <= SAT_W'(au_s3) >= (SAT_W'(aw_s3) << QUOT_BITS);
			sat_r_s4  <= SAT_W'(av_s3) >= (SAT_W'(aw_s3) << QUOT_BITS);
			neg_c_s4  <= wz_s3 ? su_s3 : !(uz_s3 || (su_s3 == sw_s3));
			neg_r_s4  <= wz_s3 ? sv_s3 : !(vz_s3 || (sv_s3 == sw_s3));
			far_s4    <= wz_s3;
			uvz_s4    <= uz_s3 && vz_s3;
		end
	end

	// ---------------- stage 5: seed the divider ----------------
	logic [FP_W-1:0]  fsh_c, fsh_r;
	logic [Q_W-1:0]   fmag_c, fmag_r;
	logic [MAG_W-1:0] rem_u_s5, rem_v_s5, div_s5;
	logic [Q_W-1:0]   q_c_s5, q_r_s5;
	ppm_flags_t       flags_s5;

	always_comb begin
		fsh_c  = fp_c_s4 >> COEF_FRAC_BITS;
		fsh_r  = fp_r_s4 >> COEF_FRAC_BITS;
		fmag_c = (fbig_c_s4 || (|fsh_c[FP_W-1:QUOT_BITS])) ? SAT_MAG
		         : Q_W'(fsh_c[QUOT_BITS-1:0]);
		fmag_r = (fbig_r_s4 || (|fsh_r[FP_W-1:QUOT_BITS])) ? SAT_MAG
		         : Q_W'(fsh_r[QUOT_BITS-1:0]);
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			rem_u_s5         <= au_s4;
			rem_v_s5         <= av_s4;
			div_s5           <= aw_s4;
			q_c_s5           <= far_s4 ? fmag_c : (sat_c_s4 ? SAT_MAG : '0);
			q_r_s5           <= far_s4 ? fmag_r : (sat_r_s4 ? SAT_MAG : '0);
			flags_s5.neg_c   <= neg_c_s4;
			flags_s5.neg_r   <= neg_r_s4;
			flags_s5.skip_c  <= far_s4 || sat_c_s4;
			flags_s5.skip_r  <= far_s4 || sat_r_s4;
			flags_s5.far     <= far_s4;
			flags_s5.uv_zero <= uvz_s4;
		end
	end

	// ---------------- stages 6..21: one quotient bit each ----------------
	assign d_valid[0] = v_s5;
	assign d_rem_u[0] = rem_u_s5;
	assign d_rem_v[0] = rem_v_s5;
	assign d_div[0]   = div_s5;
	assign d_q_c[0]   = q_c_s5;
	assign d_q_r[0]   = q_r_s5;
	assign d_flags[0] = flags_s5;

	genvar k;
	generate
		for (k = 0; k < QUOT_BITS; k++) begin : g_div
			assign d_adv[k] = !d_valid[k+1] || d_adv[k+1];

			ppm_div_stage #(
				.MAG_W (MAG_W),
				.SHIFT (QUOT_BITS - 1 - k)
			) u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (d_adv[k]),
				.in_valid  (d_valid[k]),
				.in_rem_u  (d_rem_u[k]),
				.in_rem_v  (d_rem_v[k]),
				.in_div    (d_div[k]),
				.in_q_c    (d_q_c[k]),
				.in_q_r    (d_q_r[k]),
				.in_flags  (d_flags[k]),
				.out_valid (d_valid[k+1]),
				.out_rem_u (d_rem_u[k+1]),
				.out_rem_v (d_rem_v[k+1]),
				.out_div   (d_div[k+1]),
				.out_q_c   (d_q_c[k+1]),
				.out_q_r   (d_q_r[k+1]),
				.out_flags (d_flags[k+1])
			);
		end
	endgenerate

	// ---------------- output stage: sign, saturate, bounds ----------------
	localparam logic [Q_W-1:0]   NEG_LIM = 17'd32768;
	localparam logic [Q_W-1:0]   POS_LIM = 17'd32767;
	localparam logic [OUT_W-1:0] OUT_MIN = 16'h8000;
	localparam logic [OUT_W-1:0] OUT_MAX = 16'h7FFF;

	ppm_flags_t       fl;
	logic [Q_W-1:0]   qc, qr;
	logic [OUT_W-1:0] col_nx, row_nx;
	logic             inside_nx;
	logic [OUT_W-1:0] col_q, row_q;
	logic             inside_q, far_q;

	always_comb begin
		fl = d_flags[QUOT_BITS];
		qc = d_q_c[QUOT_BITS];
		qr = d_q_r[QUOT_BITS];
		if (fl.neg_c) begin
			col_nx = (qc >= NEG_LIM) ? OUT_MIN : OUT_W'(Q_W'(0) - qc);
		end else begin
			col_nx = (qc > POS_LIM) ? OUT_MAX : qc[OUT_W-1:0];
		end
		if (fl.neg_r) begin
			row_nx = (qr >= NEG_LIM) ? OUT_MIN : OUT_W'(Q_W'(0) - qr);
		end else begin
			row_nx = (qr > POS_LIM) ? OUT_MAX : qr[OUT_W-1:0];
		end
		if (fl.far) begin
			inside_nx = fl.uv_zero && (cols_q != '0) && (rows_q != '0);
		end else begin
			inside_nx = !fl.neg_c && !fl.neg_r
			            && (col_nx < OUT_W'(cols_q)) && (row_nx < OUT_W'(rows_q));
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			col_q    <= col_nx;
			row_q    <= row_nx;
			inside_q <= inside_nx;
			far_q    <= fl.far;
		end
	end

	assign out_valid   = v_out_q;
	assign src_col     = $signed(col_q);
	assign src_row     = $signed(row_q);
	assign inside_res  = inside_q;
	assign at_infinity = far_q;

endmodule

// File: rtl/ppm_checker.sv
// Port-level checks for projective_point_map, attached by the bind below.
// Depends on ppm_pkg for the output width.
module ppm_checker import ppm_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] src_col,
	input logic signed [OUT_W-1:0] src_row,
	input logic                    inside_res,
	input logic                    at_infinity
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(src_col) && $stable(src_row)
		&& $stable(inside_res) && $stable(at_infinity))
		else $error("stalled result changed");

	// an inside point has indices within a 13-bit image
	a_inside_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res |-> (src_col[15:13] == 3'b000) && (src_row[15:13] == 3'b000))
		else $error("inside point outside image range");

	// a point at infinity is inside only at the origin
	a_far_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_infinity && inside_res |-> (src_col == '0) && (src_row == '0))
		else $error("far point inside with nonzero indices");

endmodule

bind projective_point_map ppm_checker u_ppm_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for projective_point_map: random and directed homography requests,
// APB bound writes with readback, random idling and stalls on both channels.
// Depends on ppm_pkg and the projective_point_map RTL.
module tb_top;
	import ppm_pkg::*;

	localparam int          PIX_W           = 12;
	localparam longint      ONE             = 64'sd1 <<< 32;
	localparam int          PHASES          = 8;
	localparam int          ITEMS_PER_PHASE = 107;
	localparam int          LONG_HOLD       = 300;
	localparam int          DRAIN_CYCLES    = 30;
	localparam int          REPORT_MAX      = 10;
	localparam longint      LIMIT_TIME      = 5_000_000;
	localparam logic [APB_AW-1:0] ADDR_COLS = {REG_COLS, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [8:0][COEF_W-1:0] coef;
		logic [PIX_W-1:0]       px;
		logic [PIX_W-1:0]       py;
	} map_req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] col;
		logic signed [OUT_W-1:0] row;
		logic                    in_img;
		logic                    far;
	} map_res_t;

	class map_checker;
		map_res_t         expected_maps[$];
		logic [DIM_W-1:0] cols;
		logic [DIM_W-1:0] rows;
		int unsigned      mismatches;

		function new();
			cols = COLS_RESET;
			rows = ROWS_RESET;
			mismatches = 0;
		endfunction

		function void set_bounds(logic [DIM_W-1:0] c, logic [DIM_W-1:0] r);
			cols = c;
			rows = r;
		endfunction

		function logic signed [OUT_W-1:0] clamp16(longint mag, bit neg);
			if (neg)
				return (mag >= 32768) ? 16'h8000 : 16'(-mag);
			return (mag > 32767) ? 16'h7FFF : 16'(mag);
		endfunction

		// exact dot product of one matrix row with (x, y, 1)
		function longint plane(map_req_t r, int base);
			longint a, b, c;
			a = $signed(r.coef[base]);
			b = $signed(r.coef[base + 1]);
			c = $signed(r.coef[base + 2]);
			return a * longint'(r.px) + b * longint'(r.py) + c;
		endfunction

		function logic signed [OUT_W-1:0] ratio(longint num, longint den, output bit nonneg);
			longint an, ad, q;
			an = (num < 0) ? -num : num;
			ad = (den < 0) ? -den : den;
			q = an / ad;
			if (q > 65536)
				q = 65536;
			nonneg = (num == 0) || ((num < 0) == (den < 0));
			return clamp16(q, !nonneg);
		endfunction

		function logic signed [OUT_W-1:0] far_scaled(longint num);
			longint an, p;
			an = (num < 0) ? -num : num;
			if (an >= (64'sd1 <<< FAR_LIMIT_BITS))
				p = 65536;
			else
				p = (an * longint'(INF_SCALE)) >>> 32;
			return clamp16(p, num < 0);
		endfunction

		function map_res_t project_point(map_req_t r);
			longint   u, v, w;
			bit       nc, nr;
			map_res_t m;
			u = plane(r, 0);
			v = plane(r, 3);
			w = plane(r, 6);
			m.far = (w == 0);
			if (m.far) begin
				m.col = far_scaled(u);
				m.row = far_scaled(v);
				m.in_img = (u == 0) && (v == 0) && (cols != 0) && (rows != 0);
			end else begin
				m.col = ratio(u, w, nc);
				m.row = ratio(v, w, nr);
				m.in_img = nc && nr && (int'(m.col) < int'(cols)) && (int'(m.row) < int'(rows));
			end
			return m;
		endfunction

		function void note_request(map_req_t r);
			expected_maps.push_back(project_point(r));
		endfunction

		function void check_result(map_res_t got);
			map_res_t want;
			if (expected_maps.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result with no pending request: col %0d row %0d in %0b far %0b",
						$realtime, got.col, got.row, got.in_img, got.far);
				return;
			end
			want = expected_maps.pop_front();
			if (got.col !== want.col || got.row !== want.row ||
			    got.in_img !== want.in_img || got.far !== want.far) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result wrong: col %0d/%0d row %0d/%0d in %0b/%0b far %0b/%0b",
						$realtime, want.col, got.col, want.row, got.row,
						want.in_img, got.in_img, want.far, got.far);
			end
		endfunction

		function void check_register(string name, logic [APB_DW-1:0] want,
				logic [APB_DW-1:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: %s readback: expected %0h got %0h", $realtime, name, want, got);
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel, penable, pwrite;
	logic [APB_AW-1:0]        paddr;
	logic [APB_DW-1:0]        pwdata;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     in_valid, in_stall;
	logic signed [COEF_W-1:0] coef_00, coef_01, coef_02, coef_10, coef_11, coef_12;
	logic signed [COEF_W-1:0] coef_20, coef_21, coef_22;
	logic [PIX_W-1:0]         pixel_x, pixel_y;
	logic                     out_valid, out_stall;
	logic signed [OUT_W-1:0]  src_col, src_row;
	logic                     inside_res, at_infinity;
	map_res_t                 seen;

	map_checker  pt;
	int unsigned send_pct = 0;
	int unsigned recv_pct = 0;
	bit          hold_req = 1'b0;
	int unsigned cfg_cols = COLS_RESET;
	int unsigned cfg_rows = ROWS_RESET;

	projective_point_map dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.coef_00(coef_00), .coef_01(coef_01), .coef_02(coef_02),
		.coef_10(coef_10), .coef_11(coef_11), .coef_12(coef_12),
		.coef_20(coef_20), .coef_21(coef_21), .coef_22(coef_22),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.src_col(src_col), .src_row(src_row),
		.inside_res(inside_res), .at_infinity(at_infinity)
	);

	always #5 clk = ~clk;

	assign seen = {src_col, src_row, inside_res, at_infinity};

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			pt.check_result(seen);
	end

	// result side: random stall, or a long hold when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				for (int n = 0; n < LONG_HOLD; n++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
				hold_req = 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	initial begin
		#(LIMIT_TIME);
		$display("Mismatches found");
		$finish;
	end

	function automatic longint rnd_signed(int bits);
		longint r;
		r = {$urandom(), $urandom()};
		return r >>> (63 - bits);
	endfunction

	function automatic map_req_t make_req(longint u0, longint u1, longint u2,
			longint v0, longint v1, longint v2, longint w0, longint w1, longint w2,
			int x, int y);
		map_req_t r;
		r.coef[0] = u0[COEF_W-1:0];
		r.coef[1] = u1[COEF_W-1:0];
		r.coef[2] = u2[COEF_W-1:0];
		r.coef[3] = v0[COEF_W-1:0];
		r.coef[4] = v1[COEF_W-1:0];
		r.coef[5] = v2[COEF_W-1:0];
		r.coef[6] = w0[COEF_W-1:0];
		r.coef[7] = w1[COEF_W-1:0];
		r.coef[8] = w2[COEF_W-1:0];
		r.px = x[PIX_W-1:0];
		r.py = y[PIX_W-1:0];
		return r;
	endfunction

	function automatic map_req_t random_request();
		longint u0, u1, u2, v0, v1, v2, w0, w1, w2, sgn;
		int     x, y, pick;
		x = $urandom_range(4095);
		y = $urandom_range(4095);
		pick = $urandom_range(99);
		sgn = 1;
		if (pick < 55) begin
			// plausible camera homography; flipping the whole matrix keeps the ratios
			w0 = rnd_signed(18);
			w1 = rnd_signed(18);
			w2 = ONE + rnd_signed(31);
			u0 = rnd_signed(33);
			u1 = rnd_signed(31);
			u2 = rnd_signed(42);
			v0 = rnd_signed(31);
			v1 = rnd_signed(33);
			v2 = rnd_signed(42);
			sgn = $urandom_range(1) ? -1 : 1;
		end else if (pick < 70) begin
			// cancel w exactly at this pixel
			w0 = rnd_signed(30);
			w1 = rnd_signed(30);
			w2 = -(w0 * x + w1 * y);
			u0 = 0;
			u1 = 0;
			v0 = 0;
			v1 = 0;
			u2 = ($urandom_range(2) == 0) ? 0 : rnd_signed(41);
			v2 = ($urandom_range(2) == 0) ? 0 : rnd_signed(41);
		end else if (pick < 85) begin
			// quotients just around the image bounds, including (-1, 0)
			w0 = 0;
			w1 = 0;
			w2 = ONE;
			u0 = 0;
			u1 = 0;
			v0 = 0;
			v1 = 0;
			u2 = (longint'($urandom_range(cfg_cols + 1)) - 1) * ONE + longint'($urandom());
			v2 = (longint'($urandom_range(cfg_rows + 1)) - 1) * ONE + longint'($urandom());
		end else begin
			u0 = rnd_signed(47);
			u1 = rnd_signed(47);
			u2 = rnd_signed(47);
			v0 = rnd_signed(47);
			v1 = rnd_signed(47);
			v2 = rnd_signed(47);
			w0 = rnd_signed(47);
			w1 = rnd_signed(47);
			w2 = rnd_signed(47);
		end
		return make_req(sgn * u0, sgn * u1, sgn * u2, sgn * v0, sgn * v1, sgn * v2,
			sgn * w0, sgn * w1, sgn * w2, x, y);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input map_req_t r);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		coef_00 <= r.coef[0];
		coef_01 <= r.coef[1];
		coef_02 <= r.coef[2];
		coef_10 <= r.coef[3];
		coef_11 <= r.coef[4];
		coef_12 <= r.coef[5];
		coef_20 <= r.coef[6];
		coef_21 <= r.coef[7];
		coef_22 <= r.coef[8];
		pixel_x <= r.px;
		pixel_y <= r.py;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		pt.note_request(r);
		@(negedge clk);
	endtask

	task automatic apb_access(input logic [APB_AW-1:0] addr, input logic wr,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_bound(input string name, input logic [APB_AW-1:0] addr,
			input logic [DIM_W-1:0] val);
		logic [APB_DW-1:0] word, rd;
		word = $urandom();
		// upper bits are junk the register must drop
		word[DIM_W-1:0] = val;
		apb_access(addr, 1'b1, word, rd);
		apb_access(addr, 1'b0, '0, rd);
		pt.check_register(name, APB_DW'(val), rd);
	endtask

	task automatic wait_empty();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pt.expected_maps.size() != 0);
	endtask

	task automatic directed_requests();
		send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 4095, 4095));
		send_request(make_req(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0));
		send_request(make_req(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1279, 959));
		send_request(make_req(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1280, 959));
		send_request(make_req(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 1279, 960));
		send_request(make_req(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 4095, 4095));
		send_request(make_req((64'sd1 <<< 47) - 1, (64'sd1 <<< 47) - 1, (64'sd1 <<< 47) - 1,
			(64'sd1 <<< 47) - 1, (64'sd1 <<< 47) - 1, (64'sd1 <<< 47) - 1,
			(64'sd1 <<< 47) - 1, (64'sd1 <<< 47) - 1, (64'sd1 <<< 47) - 1, 4095, 4095));
		send_request(make_req(-(64'sd1 <<< 47), -(64'sd1 <<< 47), -(64'sd1 <<< 47),
			-(64'sd1 <<< 47), -(64'sd1 <<< 47), -(64'sd1 <<< 47),
			-(64'sd1 <<< 47), -(64'sd1 <<< 47), -(64'sd1 <<< 47), 4095, 4095));
		// tiny negative quotient truncates to zero but lies outside
		send_request(make_req(0, 0, -1, 0, 0, 5, 0, 0, ONE, 17, 3));
		// negative w
		send_request(make_req(0, 0, -5 * ONE, 0, 0, -7 * ONE, 0, 0, -ONE, 9, 9));
		send_request(make_req(0, 0, -40000 * ONE, 0, 0, 40000 * ONE, 0, 0, ONE, 0, 0));
		send_request(make_req(0, 0, -32768 * ONE, 0, 0, 32767 * ONE, 0, 0, ONE, 0, 0));
		send_request(make_req(0, 0, -32769 * ONE, 0, 0, 32768 * ONE, 0, 0, ONE, 0, 0));
		send_request(make_req(0, 0, 65536 * ONE, 0, 0, -65536 * ONE, 0, 0, ONE, 0, 0));
		// w of one LSB
		send_request(make_req(0, 0, ONE, 0, 0, -ONE, 0, 0, 1, 0, 0));
		// w zero: far-point scaling and its saturation
		send_request(make_req(0, 0, ONE, 0, 0, -ONE, 0, 0, 0, 5, 5));
		send_request(make_req(0, 0, 64'sd1 <<< 20, 0, 0, -(64'sd1 <<< 20), 0, 0, 0, 5, 5));
		send_request(make_req(0, 0, 64'sd1 <<< 40, 0, 0, (64'sd1 <<< 40) - 1, 0, 0, 0, 1, 1));
		send_request(make_req(0, 0, 4294, 0, 0, -(64'sd1 <<< 40), 0, 0, 0, 1, 1));
		send_request(make_req(0, 0, 0, 0, 0, -1, 0, 0, 0, 2, 2));
		// w cancels at this pixel with u and v zero
		send_request(make_req(0, 0, 0, 0, 0, 0, ONE, 0, -100 * ONE, 100, 7));
	endtask

	initial begin
		logic [APB_DW-1:0] rd;
		logic [DIM_W-1:0]  new_cols, new_rows;
		pt = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		coef_00 = '0;
		coef_01 = '0;
		coef_02 = '0;
		coef_10 = '0;
		coef_11 = '0;
		coef_12 = '0;
		coef_20 = '0;
		coef_21 = '0;
		coef_22 = '0;
		pixel_x = '0;
		pixel_y = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				apb_access(ADDR_COLS, 1'b0, '0, rd);
				pt.check_register("image_cols", APB_DW'(COLS_RESET), rd);
				apb_access(ADDR_ROWS, 1'b0, '0, rd);
				pt.check_register("image_rows", APB_DW'(ROWS_RESET), rd);
			end else begin
				case (ph)
					1: begin new_cols = 13'd0; new_rows = 13'd4096; end
					2: begin new_cols = 13'd8191; new_rows = 13'd8191; end
					3: begin new_cols = 13'd1; new_rows = 13'd1; end
					4: begin new_cols = 13'd4096; new_rows = 13'd0; end
					5: begin new_cols = 13'd640; new_rows = 13'd480; end
					default: begin
						new_cols = DIM_W'($urandom_range(1, 4096));
						new_rows = DIM_W'($urandom_range(1, 4096));
					end
				endcase
				wait_empty();
				write_bound("image_cols", ADDR_COLS, new_cols);
				write_bound("image_rows", ADDR_ROWS, new_rows);
				pt.set_bounds(new_cols, new_rows);
				cfg_cols = 32'(new_cols);
				cfg_rows = 32'(new_rows);
			end
			case (idle_mode_t'(ph % 4))
				IDLE_NONE: begin send_pct = 0; recv_pct = 0; end
				IDLE_SEND: begin send_pct = 49; recv_pct = 0; end
				IDLE_RECV: begin send_pct = 0; recv_pct = 49; end
				default: begin send_pct = 6; recv_pct = 6; end
			endcase
			if (ph == 0)
				directed_requests();
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// back up the pipeline until the input stalls
				if (ph == 2 && i == 20)
					hold_req = 1'b1;
				if (ph == 5 && i == 50)
					wait_empty();
				send_request(random_request());
			end
		end

		in_valid <= 1'b0;
		while (pt.expected_maps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pt.mismatches == 0 && pt.expected_maps.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
